>>> rtl/core/smbw_pkg.sv
`default_nettype none

package smbw_pkg;

  // Default width of the byte offset counter
  localparam int unsigned OFFSET_BITS_DEFAULT = 16;

  // Structure header constants
  localparam logic [7:0] END_TYPE = 8'd127;
  localparam logic [7:0] MIN_LEN  = 8'd4;

  // Configuration register indexes
  localparam logic REG_TARGET_TYPE = 1'b0;
  localparam logic REG_AREA_LENGTH = 1'b1;

  // Walk phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR0 = 3'd1,
    PH_HDR1 = 3'd2,
    PH_SKIP = 3'd3,
    PH_SCAN = 3'd4,
    PH_PEND = 3'd5
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_END       = 2'd1,
    ST_SHORT     = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // One result from the walker
  typedef struct packed {
    logic        hit;
    status_t     status;
    logic [15:0] offset;
    logic [7:0]  length;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/smbw_walk.sv
`default_nettype none

module smbw_walk #(
  parameter int unsigned OFFSET_BITS = smbw_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    byte_value,
  input  wire logic          area_start,
  input  wire logic [7:0]    target_type,
  input  wire logic [15:0]   area_length,
  output smbw_pkg::res_t     res
);

  // Compare width: covers the offset, the area length and small sums
  localparam int unsigned CW = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;

  smbw_pkg::phase_t         phase, phase_next;
  logic [OFFSET_BITS-1:0]   byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0]   struct_start, struct_start_next;
  logic [7:0]               struct_kind, struct_kind_next;
  logic [7:0]               struct_len, struct_len_next;
  logic                     previous_zero, previous_zero_next;

  logic                     active;
  smbw_pkg::phase_t         ph;
  logic [OFFSET_BITS-1:0]   o;
  logic                     pz;
  logic [CW-1:0]            o_w, start_w, cap, al_w, eff_len;
  logic                     no_room, at_end, past_fmt, is_match, b_zero;

  // Resolve the phase and offset this byte is handled at
  always_comb begin
    active   = area_start ||
               ((phase != smbw_pkg::PH_IDLE) && (phase != smbw_pkg::PH_PEND));
    ph       = area_start ? smbw_pkg::PH_HDR0 : phase;
    o        = area_start ? '0 : byte_offset + OFFSET_BITS'(1);
    pz       = area_start ? 1'b0 : previous_zero;
    o_w      = CW'(o);
    start_w  = CW'(struct_start);
    cap      = CW'(1) << OFFSET_BITS;
    al_w     = CW'(area_length);
    eff_len  = (al_w > cap) ? cap : al_w;
    no_room  = (o_w + CW'(4)) > eff_len;
    at_end   = (o_w + CW'(1)) >= eff_len;
    past_fmt = o_w >= (start_w + CW'(struct_len));
    is_match = struct_kind == target_type;
    b_zero   = byte_value == 8'd0;
  end

  // Next state
  always_comb begin
    phase_next         = phase;
    byte_offset_next   = byte_offset;
    struct_start_next  = struct_start;
    struct_kind_next   = struct_kind;
    struct_len_next    = struct_len;
    previous_zero_next = previous_zero;
    if (step && active) begin
      byte_offset_next   = o;
      previous_zero_next = pz;
      phase_next         = ph;
      unique case (ph)
        smbw_pkg::PH_HDR0: begin
          if (no_room) begin
            phase_next = smbw_pkg::PH_IDLE;
          end else begin
            struct_start_next = o;
            struct_kind_next  = byte_value;
            phase_next        = smbw_pkg::PH_HDR1;
          end
        end
        smbw_pkg::PH_HDR1: begin
          struct_len_next = byte_value;
          if (byte_value < smbw_pkg::MIN_LEN || struct_kind == smbw_pkg::END_TYPE) begin
            phase_next = smbw_pkg::PH_IDLE;
          end else begin
            phase_next = smbw_pkg::PH_SKIP;
          end
        end
        smbw_pkg::PH_SKIP: begin
          if (at_end) begin
            phase_next = is_match ? smbw_pkg::PH_PEND : smbw_pkg::PH_IDLE;
          end else if (past_fmt) begin
            phase_next         = smbw_pkg::PH_SCAN;
            previous_zero_next = b_zero;
          end
        end
        smbw_pkg::PH_SCAN: begin
          if (at_end) begin
            phase_next = is_match ? smbw_pkg::PH_PEND : smbw_pkg::PH_IDLE;
          end else if (pz && b_zero) begin
            previous_zero_next = 1'b0;
            phase_next         = smbw_pkg::PH_HDR0;
          end else begin
            previous_zero_next = b_zero;
          end
        end
        default: phase_next = smbw_pkg::PH_IDLE;
      endcase
    end else if (step && phase == smbw_pkg::PH_PEND) begin
      phase_next = smbw_pkg::PH_IDLE;
    end
  end

  // Result for this byte
  always_comb begin
    res = '0;
    if (step && active) begin
      unique case (ph)
        smbw_pkg::PH_HDR0: begin
          if (no_room) begin
            res.hit    = 1'b1;
            res.status = smbw_pkg::ST_EXHAUSTED;
          end
        end
        smbw_pkg::PH_HDR1: begin
          if (byte_value < smbw_pkg::MIN_LEN) begin
            res.hit    = 1'b1;
            res.status = smbw_pkg::ST_SHORT;
          end else if (struct_kind == smbw_pkg::END_TYPE) begin
            res.hit    = 1'b1;
            res.status = smbw_pkg::ST_END;
          end
        end
        smbw_pkg::PH_SKIP, smbw_pkg::PH_SCAN: begin
          if (at_end || (ph == smbw_pkg::PH_SCAN && pz && b_zero && is_match)) begin
            res.hit = 1'b1;
            if (is_match) begin
              res.status = smbw_pkg::ST_MATCH;
              res.offset = start_w[15:0];
              res.length = struct_len;
            end else begin
              res.status = smbw_pkg::ST_EXHAUSTED;
            end
          end
        end
        default: res = '0;
      endcase
    end else if (step && phase == smbw_pkg::PH_PEND) begin
      res.hit    = 1'b1;
      res.status = smbw_pkg::ST_EXHAUSTED;
    end
  end

  // Hold walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= smbw_pkg::PH_IDLE;
      byte_offset   <= '0;
      struct_start  <= '0;
      struct_kind   <= '0;
      struct_len    <= '0;
      previous_zero <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_offset   <= byte_offset_next;
      struct_start  <= struct_start_next;
      struct_kind   <= struct_kind_next;
      struct_len    <= struct_len_next;
      previous_zero <= previous_zero_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/smbios_structure_walker.sv
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------
// input    | in        | in_valid/in_stall  | byte_value[7:0], area_start
// output   | out       | out_valid/out_stall| status[1:0], table_offset[15:0],
//          |           |                    | match_length[7:0]
// config   | in        | cfg_write          | cfg_index, cfg_data[15:0]
//
// One byte per cycle sustained while the output is not stalled; a request waits in
// the input register, and its result, if any, is loaded from there into the output register.
// The walker updates its state once for each byte that steps.
// rst is synchronous and clears the walk state, config registers and valid flags.
// A stalled result holds the input register; a new byte is taken whenever the
// input register moves on in the same cycle or is empty.

module smbios_structure_walker #(
  parameter int unsigned OFFSET_BITS = smbw_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic        area_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      table_offset,
  output logic [7:0]       match_length,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [7:0]     target_type;
  logic [15:0]    area_length;
  logic           in_q_valid;
  logic [7:0]     byte_q;
  logic           start_q;
  logic           out_free;
  logic           step;
  logic           accept;
  smbw_pkg::res_t res;

  assign out_free = !out_valid || !out_stall;
  assign step     = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= '0;
      area_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        smbw_pkg::REG_TARGET_TYPE: target_type <= cfg_data[7:0];
        smbw_pkg::REG_AREA_LENGTH: area_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the input request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q  <= byte_value;
      start_q <= area_start;
    end
  end

  smbw_walk #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_value (byte_q),
    .area_start (start_q),
    .target_type(target_type),
    .area_length(area_length),
    .res        (res)
  );

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.hit) begin
      status       <= res.status;
      table_offset <= res.offset;
      match_length <= res.length;
    end
  end

endmodule

`default_nettype wire
